[hdl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// Moving average package
// Shared constants, field widths and the sequencer state type for the
// multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int unsigned CHANNELS_DEF    = 4;
  localparam int unsigned WINDOW_DEF      = 5;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CHANNEL_W = 2;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned AVERAGE_W = 16;
  localparam int unsigned FILLED_W  = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

[hdl/mma_in_if.sv]
// ----------------------------------------------------------------------------
// Moving average input channel
// Valid/ready channel carrying one speed sample and its channel number.
// ----------------------------------------------------------------------------
interface mma_in_if;

  logic                           valid;
  logic                           ready;
  logic [mma_pkg::CHANNEL_W-1:0]  channel;
  logic [mma_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);

endinterface

[hdl/mma_out_if.sv]
// ----------------------------------------------------------------------------
// Moving average output channel
// Valid/ready channel carrying one window average with its channel and fill.
// ----------------------------------------------------------------------------
interface mma_out_if;

  logic                           valid;
  logic                           ready;
  logic [mma_pkg::CHANNEL_W-1:0]  channel_out;
  logic [mma_pkg::AVERAGE_W-1:0]  average;
  logic [mma_pkg::FILLED_W-1:0]   filled;

  modport source (output valid, output channel_out, output average, output filled,
                  input ready);
  modport sink   (input valid, input channel_out, input average, input filled,
                  output ready);

endinterface

[hdl/mma_div.sv]
// ----------------------------------------------------------------------------
// Moving average divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mma_div #(
  parameter int unsigned DIVIDEND_W = 19,
  parameter int unsigned DIVISOR_W  = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W:0]    rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hdl/multichannel_moving_average.sv]
// ----------------------------------------------------------------------------
// Multichannel moving average
// Per-channel sliding-window average of unsigned speed samples.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the valid/ready input channel, each beat naming a
// channel and carrying one sample. A beat for a channel number at or above
// CHANNELS is taken and dropped without any result. Every other beat yields
// exactly one result beat on the output channel: the channel, the truncated
// average of the samples in that channel's window, and the fill count.
// The result comes from the shared restoring divider, which produces one
// quotient bit per cycle. One sample is processed at a time, so a new input
// beat is taken only after the previous result has been loaded into the
// output register. A finished result waits in the output register; while it
// waits the next sample is taken and worked on, and only its final hand-over
// waits for the receiver.
// Reset clears all sums, write slots and fill counts. The sample ring needs
// no clearing pass: slots beyond the fill count are treated as zero.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
  parameter int unsigned CHANNELS    = mma_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW      = mma_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mma_in_if.sink       in_i,
  mma_out_if.source    out_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned DEPTH  = CHANNELS * WINDOW;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW     = mma_pkg::CHANNEL_W;

  mma_pkg::state_e state_q, state_d;

  logic [CW-1:0]          ch_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SUM_W-1:0]       sum_q  [CHANNELS];
  logic [SLOT_W-1:0]      slot_q [CHANNELS];
  logic [CNT_W-1:0]       fill_q [CHANNELS];
  logic [SAMPLE_BITS-1:0] ring_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;

  logic                   out_valid_q;
  logic [CW-1:0]          out_ch_q;
  logic [mma_pkg::AVERAGE_W-1:0] out_avg_q;
  logic [mma_pkg::FILLED_W-1:0]  out_fill_q;

  logic                   in_ready;
  logic                   accept;
  logic                   ch_ok;
  logic                   ring_re;
  logic                   upd_en;
  logic                   out_load;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;

  logic [CH_W+CW-1:0]     ch_ext;
  logic [CH_W-1:0]        ch_idx;
  logic [SAMPLE_BITS+mma_pkg::SAMPLE_W-1:0] smp_ext;
  logic [AW-1:0]          addr;
  logic [SLOT_W-1:0]      slot_cur;
  logic [CNT_W-1:0]       fill_cur;
  logic [CNT_W-1:0]       fill_new;
  logic [SLOT_W-1:0]      slot_new;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SUM_W-1:0]       sum_new;
  logic [SUM_W+mma_pkg::AVERAGE_W-1:0] quo_ext;
  logic [CNT_W+mma_pkg::FILLED_W-1:0]  fill_ext;

  assign accept  = in_i.valid && in_ready;
  assign ch_ok   = (32'(in_i.channel) < CHANNELS);
  assign smp_ext = (SAMPLE_BITS + mma_pkg::SAMPLE_W)'(in_i.sample);

  assign ch_ext   = (CH_W + CW)'(ch_q);
  assign ch_idx   = ch_ext[CH_W-1:0];
  assign slot_cur = slot_q[ch_idx];
  assign fill_cur = fill_q[ch_idx];
  assign addr     = AW'(ch_idx * WINDOW) + AW'(slot_cur);

  assign old_smp  = (fill_cur < CNT_W'(WINDOW)) ? '0 : rd_data_q;
  assign sum_new  = sum_q[ch_idx] - SUM_W'(old_smp) + SUM_W'(smp_q);
  assign fill_new = (fill_cur < CNT_W'(WINDOW)) ? (fill_cur + CNT_W'(1)) : fill_cur;
  assign slot_new = (slot_cur == SLOT_W'(WINDOW - 1)) ? '0 : (slot_cur + SLOT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mma_pkg::ST_IDLE: begin
        if (accept && ch_ok) begin
          state_d = mma_pkg::ST_READ;
        end
      end
      mma_pkg::ST_READ:   state_d = mma_pkg::ST_UPDATE;
      mma_pkg::ST_UPDATE: state_d = mma_pkg::ST_DIVIDE;
      mma_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_d = mma_pkg::ST_DONE;
        end
      end
      mma_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = mma_pkg::ST_IDLE;
        end
      end
      default: state_d = mma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ring_re  = 1'b0;
    upd_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      mma_pkg::ST_IDLE:   in_ready = 1'b1;
      mma_pkg::ST_READ:   ring_re  = 1'b1;
      mma_pkg::ST_UPDATE: upd_en   = 1'b1;
      mma_pkg::ST_DIVIDE: ;
      mma_pkg::ST_DONE:   out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mma_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i]  <= '0;
        slot_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (upd_en) begin
        sum_q[ch_idx]  <= sum_new;
        slot_q[ch_idx] <= slot_new;
        fill_q[ch_idx] <= fill_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= in_i.channel;
      smp_q <= smp_ext[SAMPLE_BITS-1:0];
    end
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_avg_q  <= quo_ext[mma_pkg::AVERAGE_W-1:0];
      out_fill_q <= fill_ext[mma_pkg::FILLED_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      ring_q[addr] <= smp_q;
    end
    if (ring_re) begin
      rd_data_q <= ring_q[addr];
    end
  end

  mma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd_en),
    .dividend_i (sum_new),
    .divisor_i  (fill_new),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign quo_ext  = (SUM_W + mma_pkg::AVERAGE_W)'(quotient);
  assign fill_ext = (CNT_W + mma_pkg::FILLED_W)'(fill_cur);

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.average     = out_avg_q;
  assign out_o.filled      = out_fill_q;

endmodule

[verif/mma_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving average scoreboard
// Keeps its own window, running sum, write slot and fill count for every
// channel. It works out the average that each accepted sample beat should
// produce and checks every result beat against the oldest one outstanding.
// ----------------------------------------------------------------------------
package mma_tb_pkg;

  import mma_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW_DEF);

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [AVERAGE_W-1:0] average;
    logic [FILLED_W-1:0]  filled;
  } average_beat_t;

  class mma_scoreboard;

    logic [SAMPLE_W-1:0] window_ring [CHANNELS_DEF][WINDOW_DEF];
    logic [SUM_W-1:0]    window_sum  [CHANNELS_DEF];
    int unsigned         next_slot   [CHANNELS_DEF];
    logic [FILLED_W-1:0] fill_count  [CHANNELS_DEF];
    average_beat_t       expected_averages [$];
    int unsigned         errors;

    function new();
      foreach (window_ring[c, s]) window_ring[c][s] = '0;
      foreach (window_sum[c]) begin
        window_sum[c] = '0;
        next_slot[c]  = 0;
        fill_count[c] = '0;
      end
      errors = 0;
    endfunction

    function void note_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
      average_beat_t beat;
      if (ch >= CHANNELS_DEF) return;
      window_sum[ch] = window_sum[ch] - SUM_W'(window_ring[ch][next_slot[ch]]) + SUM_W'(smp);
      window_ring[ch][next_slot[ch]] = smp;
      next_slot[ch] = (next_slot[ch] + 1) % WINDOW_DEF;
      if (fill_count[ch] < FILLED_W'(WINDOW_DEF)) fill_count[ch] = fill_count[ch] + FILLED_W'(1);
      beat.channel = ch;
      beat.average = AVERAGE_W'(window_sum[ch] / SUM_W'(fill_count[ch]));
      beat.filled  = fill_count[ch];
      expected_averages.push_back(beat);
    endfunction

    function void compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(input average_beat_t got);
      average_beat_t want;
      if (expected_averages.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual channel %0d average %0d filled %0d",
                 $time, got.channel, got.average, got.filled);
        return;
      end
      want = expected_averages.pop_front();
      compare_field("channel_out", 32'(want.channel), 32'(got.channel));
      compare_field("average", 32'(want.average), 32'(got.average));
      compare_field("filled", 32'(want.filled), 32'(got.filled));
    endfunction

    function int unsigned pending();
      return expected_averages.size();
    endfunction

  endclass

endpackage

[verif/multichannel_moving_average_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multichannel moving average testbench
// Drives directed and random speed samples into the block under changing
// idle patterns on both sides, including a long receiver hold-off, and
// checks every result beat against the scoreboard's own window averages.
// ----------------------------------------------------------------------------
module multichannel_moving_average_tb;

  import mma_pkg::*;
  import mma_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 650;
  localparam int unsigned PHASE_ITEMS    = RANDOM_ITEMS / 3 + 1;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  bit                   hold_due;
  logic [CHANNEL_W-1:0] last_channel;

  mma_in_if  in_if ();
  mma_out_if out_if ();

  mma_scoreboard sb = new();

  multichannel_moving_average u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(ch, smp);
  endtask

  task automatic wait_for_averages();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(65535, 65520));
      3:       return SAMPLE_W'($urandom_range(15));
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct, input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (with_hold && i == 30) hold_due = 1'b1;
      if ($urandom_range(3) != 0) last_channel = CHANNEL_W'($urandom_range(CHANNELS_DEF - 1));
      send_sample(last_channel, pick_sample());
    end
    wait_for_averages();
  endtask

  // Result side: checks each accepted beat, then chooses ready for the next cycle.
  initial begin
    int unsigned   stall_left;
    bit            hold_taken;
    average_beat_t beat;
    stall_left   = 0;
    hold_taken   = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        beat.channel = out_if.channel_out;
        beat.average = out_if.average;
        beat.filled  = out_if.filled;
        sb.check_result(beat);
      end
      if (hold_due && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.sample  = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_due      = 1'b0;
    last_channel  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A full-scale window that fills, saturates and then loses its oldest sample.
    repeat (6) send_sample(2'd0, 16'hFFFF);
    send_sample(2'd0, 16'h0000);
    send_sample(2'd1, 16'h0000);
    send_sample(2'd1, 16'hFFFF);
    // Truncation of a partly filled window and mid-scale bit patterns.
    send_sample(2'd2, 16'h0001);
    send_sample(2'd2, 16'h0002);
    send_sample(2'd2, 16'h7FFF);
    send_sample(2'd2, 16'h8000);
    send_sample(2'd2, 16'hFFFE);
    send_sample(2'd2, 16'h0003);
    send_sample(2'd3, 16'hAAAA);
    send_sample(2'd3, 16'h5555);
    send_sample(2'd3, 16'hAAAA);
    send_sample(2'd3, 16'h5555);
    send_sample(2'd3, 16'hAAAA);
    send_sample(2'd3, 16'h5555);
    wait_for_averages();

    run_random(PHASE_ITEMS, 10, 73, 1'b0);
    run_random(PHASE_ITEMS, 73, 10, 1'b0);
    run_random(PHASE_ITEMS, 0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
